FILE: rtl/tcli_pkg.sv
// ----------------------------------------------------------------------------
// tcli_pkg: shared widths, register map and types
// Constants and the sideband type used by the interpolator and its divider.
// ----------------------------------------------------------------------------
package tcli_pkg;

  localparam int COORD_W  = 32;              // Q16.16 coordinates and altitudes
  localparam int ROWCOL_W = 16;
  localparam int CSIZE_W  = 31;
  localparam int TOL_W    = 20;

  // Stream word layouts.
  localparam int IN_W         = 9 * COORD_W + 2 * ROWCOL_W;
  localparam int OUT_FIELDS_W = 1 + COORD_W + 2 * ROWCOL_W;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE = 3'd2;
  localparam logic [2:0] REG_GRID_COLS = 3'd3;
  localparam logic [2:0] REG_GRID_ROWS = 3'd4;
  localparam logic [2:0] REG_INV_ALT   = 3'd5;
  localparam logic [2:0] REG_EDGE_TOL  = 3'd6;

  localparam logic signed [COORD_W-1:0] ORIGIN_RST   = '0;
  localparam logic [CSIZE_W-1:0]        CELL_SIZE_RST = CSIZE_W'(65536);
  localparam logic [ROWCOL_W-1:0]       GRID_DIM_RST  = ROWCOL_W'(1024);
  localparam logic signed [COORD_W-1:0] INV_ALT_RST   = -32'sd655353446;
  localparam logic [TOL_W-1:0]          EDGE_TOL_RST  = TOL_W'(42950);

  // Datapath widths.
  localparam int PROD_W = ROWCOL_W + CSIZE_W;    // index times cell size
  localparam int PT_W   = PROD_W + 1;            // cell point, signed
  localparam int D_W    = PT_W + 1;              // point minus vertex
  localparam int E_W    = COORD_W + 1;           // vertex difference
  localparam int DLO_W  = 24;
  localparam int DHI_W  = D_W - DLO_W;
  localparam int PP_W   = E_W + DHI_W;           // partial edge product
  localparam int EP_W   = E_W + D_W;             // full edge product
  localparam int V_W    = EP_W + 1;              // orientation value
  localparam int DEN_W  = V_W + 2;
  localparam int VLO_W  = 28;
  localparam int ZP_W   = COORD_W + VLO_W + 1;   // partial numerator product
  localparam int NUM_W  = COORD_W + V_W + 2;
  localparam int REM_W  = NUM_W;
  localparam int QUO_W  = COORD_W - 1;
  localparam int DIV_STAGES = QUO_W;

  typedef struct packed {
    logic                       write;
    logic                       sat;
    logic                       neg;
    logic                       den_zero;
    logic signed [COORD_W-1:0]  z0;
    logic [ROWCOL_W-1:0]        row;
    logic [ROWCOL_W-1:0]        col;
  } side_t;

endpackage

FILE: rtl/tcli_divider.sv
// ----------------------------------------------------------------------------
// tcli_divider: pipelined restoring divider
// One quotient bit per stage, most significant first, with sideband carried.
// ----------------------------------------------------------------------------
module tcli_divider (
  input  logic                             clk_i,
  input  logic [tcli_pkg::DIV_STAGES-1:0]  en_i,
  input  logic [tcli_pkg::REM_W-1:0]       rem_i,
  input  logic [tcli_pkg::DEN_W-1:0]       den_i,
  input  tcli_pkg::side_t                  side_i,
  output logic [tcli_pkg::QUO_W-1:0]       quo_o,
  output logic [tcli_pkg::REM_W-1:0]       rem_o,
  output logic [tcli_pkg::DEN_W-1:0]       den_o,
  output tcli_pkg::side_t                  side_o
);
  import tcli_pkg::*;

  logic [REM_W-1:0] rem_q  [DIV_STAGES];
  logic [DEN_W-1:0] den_q  [DIV_STAGES];
  logic [QUO_W-1:0] quo_q  [DIV_STAGES];
  side_t            side_q [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam int BitPos = DIV_STAGES - 1 - i;
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] trial;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    side_t            side_in;

    if (i == 0) begin : g_first
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign den_in  = den_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = REM_W'(den_in) << BitPos;

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        if (rem_in >= trial) begin
          rem_q[i] <= rem_in - trial;
          quo_q[i] <= quo_in | (QUO_W'(1) << BitPos);
        end else begin
          rem_q[i] <= rem_in;
          quo_q[i] <= quo_in;
        end
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign quo_o  = quo_q[DIV_STAGES-1];
  assign rem_o  = rem_q[DIV_STAGES-1];
  assign den_o  = den_q[DIV_STAGES-1];
  assign side_o = side_q[DIV_STAGES-1];

endmodule

FILE: rtl/tin_cell_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// tin_cell_linear_interpolator_unit: triangle-to-grid altitude interpolation
// Tests a grid cell point against a triangle and returns its planar altitude.
// ----------------------------------------------------------------------------
// Usage:
// Each input word on s_axis carries one triangle (three x, y, altitude
// vertices) and one cell index. Each output word on m_axis carries the
// write flag, the rounded and saturated altitude, and the row and column.
// Grid origin, cell size, grid size, invalid-altitude marker and edge
// tolerance are set over the APB port while the block is idle.
// The pipeline is 43 register stages deep: eleven for the cell point,
// the orientation products and the numerator, 31 for the one-bit-per-stage
// quotient, and one output register. One word is taken every cycle when
// nothing stalls. When m_axis_tready is low, the stages behind the output
// close up their empty slots, so s_axis_tready drops only once all stages
// hold data; nothing is lost or repeated. Reset empties the pipeline and
// loads the configuration defaults.
module tin_cell_linear_interpolator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // vx0, vy0, vz0, vx1, vy1, vz1, vx2, vy2, vz2, cell_row, cell_col
  input  logic [tcli_pkg::IN_W-1:0]          s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // write_cell, altitude, out_row, out_col, zero fill
  output logic [tcli_pkg::OUT_W-1:0]         m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tcli_pkg::APB_AW-1:0]        paddr,
  input  logic [tcli_pkg::APB_DW-1:0]        pwdata,
  output logic [tcli_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import tcli_pkg::*;

  localparam int PRE_STAGES = 11;
  localparam int NST        = PRE_STAGES + DIV_STAGES + 1;
  localparam int NXT  [3] = '{1, 2, 0};
  localparam int ZSEL [3] = '{2, 0, 1};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] cfg_origin_x_q, cfg_origin_y_q, cfg_inv_alt_q;
  logic [CSIZE_W-1:0]        cfg_cell_size_q;
  logic [ROWCOL_W-1:0]       cfg_cols_q, cfg_rows_q;
  logic [TOL_W-1:0]          cfg_tol_q;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_origin_x_q  <= ORIGIN_RST;
      cfg_origin_y_q  <= ORIGIN_RST;
      cfg_cell_size_q <= CELL_SIZE_RST;
      cfg_cols_q      <= GRID_DIM_RST;
      cfg_rows_q      <= GRID_DIM_RST;
      cfg_inv_alt_q   <= INV_ALT_RST;
      cfg_tol_q       <= EDGE_TOL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIGIN_X:  cfg_origin_x_q  <= pwdata;
        REG_ORIGIN_Y:  cfg_origin_y_q  <= pwdata;
        REG_CELL_SIZE: cfg_cell_size_q <= pwdata[CSIZE_W-1:0];
        REG_GRID_COLS: cfg_cols_q      <= pwdata[ROWCOL_W-1:0];
        REG_GRID_ROWS: cfg_rows_q      <= pwdata[ROWCOL_W-1:0];
        REG_INV_ALT:   cfg_inv_alt_q   <= pwdata;
        REG_EDGE_TOL:  cfg_tol_q       <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X:  prdata = cfg_origin_x_q;
      REG_ORIGIN_Y:  prdata = cfg_origin_y_q;
      REG_CELL_SIZE: prdata = APB_DW'(cfg_cell_size_q);
      REG_GRID_COLS: prdata = APB_DW'(cfg_cols_q);
      REG_GRID_ROWS: prdata = APB_DW'(cfg_rows_q);
      REG_INV_ALT:   prdata = cfg_inv_alt_q;
      REG_EDGE_TOL:  prdata = APB_DW'(cfg_tol_q);
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage valid bits and load enables
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;
  logic [NST-1:0] vld_in;

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    en[NST-1] = !vld_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vld_in        = {vld_q[NST-2:0], s_axis_tvalid};
  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] in_x [3];
  logic signed [COORD_W-1:0] in_y [3];
  logic signed [COORD_W-1:0] in_z [3];
  logic [ROWCOL_W-1:0]       in_row, in_col;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_x[i] = s_axis_tdata[3*COORD_W*i +: COORD_W];
      in_y[i] = s_axis_tdata[3*COORD_W*i + COORD_W +: COORD_W];
      in_z[i] = s_axis_tdata[3*COORD_W*i + 2*COORD_W +: COORD_W];
    end
    in_row = s_axis_tdata[9*COORD_W +: ROWCOL_W];
    in_col = s_axis_tdata[9*COORD_W + ROWCOL_W +: ROWCOL_W];
  end

  // --------------------------------------------------------------------------
  // Stage 0: validity checks and index times cell size
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] a_x_q [3];
  logic signed [COORD_W-1:0] a_y_q [3];
  logic signed [COORD_W-1:0] a_z_q [3];
  logic [ROWCOL_W-1:0]       a_row_q, a_col_q;
  logic                      a_ok_q;
  logic [PROD_W-1:0]         a_px_q, a_py_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_x_q   <= in_x;
      a_y_q   <= in_y;
      a_z_q   <= in_z;
      a_row_q <= in_row;
      a_col_q <= in_col;
      a_ok_q  <= (in_z[0] != cfg_inv_alt_q) && (in_z[1] != cfg_inv_alt_q) &&
                 (in_z[2] != cfg_inv_alt_q) && (in_row < cfg_rows_q) &&
                 (in_col < cfg_cols_q);
      a_px_q  <= PROD_W'(in_col) * PROD_W'(cfg_cell_size_q);
      a_py_q  <= PROD_W'(in_row) * PROD_W'(cfg_cell_size_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: cell point and triangle edge vectors
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] b_x_q [3];
  logic signed [COORD_W-1:0] b_y_q [3];
  logic signed [COORD_W-1:0] b_z_q [3];
  logic signed [E_W-1:0]     b_ex_q [3];
  logic signed [E_W-1:0]     b_ey_q [3];
  logic signed [PT_W-1:0]    b_px_q, b_py_q;
  logic [ROWCOL_W-1:0]       b_row_q, b_col_q;
  logic                      b_ok_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_x_q   <= a_x_q;
      b_y_q   <= a_y_q;
      b_z_q   <= a_z_q;
      b_px_q  <= PT_W'(cfg_origin_x_q) + $signed({1'b0, a_px_q});
      b_py_q  <= PT_W'(cfg_origin_y_q) + $signed({1'b0, a_py_q});
      for (int j = 0; j < 3; j++) begin
        b_ex_q[j] <= E_W'(a_x_q[NXT[j]]) - E_W'(a_x_q[j]);
        b_ey_q[j] <= E_W'(a_y_q[NXT[j]]) - E_W'(a_y_q[j]);
      end
      b_row_q <= a_row_q;
      b_col_q <= a_col_q;
      b_ok_q  <= a_ok_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: point relative to each vertex
  // --------------------------------------------------------------------------
  logic signed [D_W-1:0]     c_dx_q [3];
  logic signed [D_W-1:0]     c_dy_q [3];
  logic signed [E_W-1:0]     c_ex_q [3];
  logic signed [E_W-1:0]     c_ey_q [3];
  logic signed [COORD_W-1:0] c_z_q [3];
  logic [ROWCOL_W-1:0]       c_row_q, c_col_q;
  logic                      c_ok_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        c_dx_q[i] <= D_W'(b_px_q) - D_W'(b_x_q[i]);
        c_dy_q[i] <= D_W'(b_py_q) - D_W'(b_y_q[i]);
      end
      c_ex_q  <= b_ex_q;
      c_ey_q  <= b_ey_q;
      c_z_q   <= b_z_q;
      c_row_q <= b_row_q;
      c_col_q <= b_col_q;
      c_ok_q  <= b_ok_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: split edge products, and magnitude flags for the edge test
  // --------------------------------------------------------------------------
  logic signed [PP_W-1:0]    d_pah_q [3];
  logic signed [PP_W-1:0]    d_pal_q [3];
  logic signed [PP_W-1:0]    d_pbh_q [3];
  logic signed [PP_W-1:0]    d_pbl_q [3];
  logic [2:0]                d_xneg_q, d_xzero_q, d_xbig_q;
  logic [2:0]                d_yneg_q, d_yzero_q, d_ybig_q;
  logic [TOL_W-1:0]          d_xmag_q [3];
  logic [TOL_W-1:0]          d_ymag_q [3];
  logic signed [COORD_W-1:0] d_z_q [3];
  logic [ROWCOL_W-1:0]       d_row_q, d_col_q;
  logic                      d_ok_q;
  logic [D_W-1:0]            c_xabs [3];
  logic [D_W-1:0]            c_yabs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_xabs[i] = c_dx_q[i][D_W-1] ? D_W'(-c_dx_q[i]) : D_W'(c_dx_q[i]);
      c_yabs[i] = c_dy_q[i][D_W-1] ? D_W'(-c_dy_q[i]) : D_W'(c_dy_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        d_pah_q[j] <= c_ex_q[j] * $signed(c_dy_q[NXT[j]][D_W-1:DLO_W]);
        d_pal_q[j] <= c_ex_q[j] * $signed({1'b0, c_dy_q[NXT[j]][DLO_W-1:0]});
        d_pbh_q[j] <= $signed(c_dx_q[NXT[j]][D_W-1:DLO_W]) * c_ey_q[j];
        d_pbl_q[j] <= $signed({1'b0, c_dx_q[NXT[j]][DLO_W-1:0]}) * c_ey_q[j];
      end
      for (int i = 0; i < 3; i++) begin
        d_xneg_q[i]  <= c_dx_q[i][D_W-1];
        d_yneg_q[i]  <= c_dy_q[i][D_W-1];
        d_xzero_q[i] <= (c_dx_q[i] == '0);
        d_yzero_q[i] <= (c_dy_q[i] == '0);
        d_xbig_q[i]  <= |c_xabs[i][D_W-1:TOL_W];
        d_ybig_q[i]  <= |c_yabs[i][D_W-1:TOL_W];
        d_xmag_q[i]  <= c_xabs[i][TOL_W-1:0];
        d_ymag_q[i]  <= c_yabs[i][TOL_W-1:0];
      end
      d_z_q   <= c_z_q;
      d_row_q <= c_row_q;
      d_col_q <= c_col_q;
      d_ok_q  <= c_ok_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: join edge products; products of vertex offsets along each edge
  // --------------------------------------------------------------------------
  logic signed [EP_W-1:0]    e_pa_q [3];
  logic signed [EP_W-1:0]    e_pb_q [3];
  logic [2:0]                e_xeasy_q, e_xbig_q, e_yeasy_q, e_ybig_q;
  logic [2*TOL_W-1:0]        e_xprod_q [3];
  logic [2*TOL_W-1:0]        e_yprod_q [3];
  logic signed [COORD_W-1:0] e_z_q [3];
  logic [ROWCOL_W-1:0]       e_row_q, e_col_q;
  logic                      e_ok_q;

  // An offset product is at most the tolerance for free when it is zero or
  // negative; with a magnitude of 2^20 or more on either side it is too large.
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int j = 0; j < 3; j++) begin
        e_pa_q[j]    <= (EP_W'(d_pah_q[j]) <<< DLO_W) + EP_W'(d_pal_q[j]);
        e_pb_q[j]    <= (EP_W'(d_pbh_q[j]) <<< DLO_W) + EP_W'(d_pbl_q[j]);
        e_xeasy_q[j] <= d_xzero_q[j] || d_xzero_q[NXT[j]] ||
                        (d_xneg_q[j] != d_xneg_q[NXT[j]]);
        e_yeasy_q[j] <= d_yzero_q[j] || d_yzero_q[NXT[j]] ||
                        (d_yneg_q[j] != d_yneg_q[NXT[j]]);
        e_xbig_q[j]  <= d_xbig_q[j] || d_xbig_q[NXT[j]];
        e_ybig_q[j]  <= d_ybig_q[j] || d_ybig_q[NXT[j]];
        e_xprod_q[j] <= (2*TOL_W)'(d_xmag_q[j]) * (2*TOL_W)'(d_xmag_q[NXT[j]]);
        e_yprod_q[j] <= (2*TOL_W)'(d_ymag_q[j]) * (2*TOL_W)'(d_ymag_q[NXT[j]]);
      end
      e_z_q   <= d_z_q;
      e_row_q <= d_row_q;
      e_col_q <= d_col_q;
      e_ok_q  <= d_ok_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: orientation values and the offset part of the edge test
  // --------------------------------------------------------------------------
  logic signed [V_W-1:0]     f_v_q [3];
  logic [2:0]                f_oe_q;
  logic signed [COORD_W-1:0] f_z_q [3];
  logic [ROWCOL_W-1:0]       f_row_q, f_col_q;
  logic                      f_ok_q;
  logic [2*TOL_W-1:0]        tol_wide;

  assign tol_wide = (2*TOL_W)'(cfg_tol_q);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int j = 0; j < 3; j++) begin
        f_v_q[j]  <= V_W'(e_pa_q[j]) - V_W'(e_pb_q[j]);
        f_oe_q[j] <= (e_xeasy_q[j] || (!e_xbig_q[j] && (e_xprod_q[j] <= tol_wide))) &&
                     (e_yeasy_q[j] || (!e_ybig_q[j] && (e_yprod_q[j] <= tol_wide)));
      end
      f_z_q   <= e_z_q;
      f_row_q <= e_row_q;
      f_col_q <= e_col_q;
      f_ok_q  <= e_ok_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: tolerance compares, area sum, split numerator products
  // --------------------------------------------------------------------------
  logic [2:0]                g_gt_q, g_lt_q, g_near_q, g_oe_q;
  logic signed [DEN_W-1:0]   g_den_q;
  logic signed [ZP_W-1:0]    g_nh_q [3];
  logic signed [ZP_W-1:0]    g_nm_q [3];
  logic signed [ZP_W-1:0]    g_nl_q [3];
  logic signed [COORD_W-1:0] g_z0_q;
  logic [ROWCOL_W-1:0]       g_row_q, g_col_q;
  logic                      g_ok_q;
  logic signed [V_W-1:0]     tol_v;

  assign tol_v = V_W'(cfg_tol_q);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int j = 0; j < 3; j++) begin
        g_gt_q[j]   <= f_v_q[j] > tol_v;
        g_lt_q[j]   <= f_v_q[j] < tol_v;
        g_near_q[j] <= (f_v_q[j] < tol_v) && (f_v_q[j] > -tol_v);
        g_nh_q[j]   <= f_z_q[ZSEL[j]] * $signed(f_v_q[j][V_W-1:2*VLO_W]);
        g_nm_q[j]   <= f_z_q[ZSEL[j]] * $signed({1'b0, f_v_q[j][2*VLO_W-1:VLO_W]});
        g_nl_q[j]   <= f_z_q[ZSEL[j]] * $signed({1'b0, f_v_q[j][VLO_W-1:0]});
      end
      g_oe_q  <= f_oe_q;
      g_den_q <= DEN_W'(f_v_q[0]) + DEN_W'(f_v_q[1]) + DEN_W'(f_v_q[2]);
      g_z0_q  <= f_z_q[0];
      g_row_q <= f_row_q;
      g_col_q <= f_col_q;
      g_ok_q  <= f_ok_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: coverage decision and joined numerator products
  // --------------------------------------------------------------------------
  logic                      h_write_q;
  logic signed [NUM_W-1:0]   h_np_q [3];
  logic signed [DEN_W-1:0]   h_den_q;
  logic signed [COORD_W-1:0] h_z0_q;
  logic [ROWCOL_W-1:0]       h_row_q, h_col_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      h_write_q <= g_ok_q && ((&g_gt_q) || (&g_lt_q) || (|(g_near_q & g_oe_q)));
      for (int j = 0; j < 3; j++) begin
        h_np_q[j] <= (NUM_W'(g_nh_q[j]) <<< (2*VLO_W)) +
                     (NUM_W'(g_nm_q[j]) <<< VLO_W) + NUM_W'(g_nl_q[j]);
      end
      h_den_q <= g_den_q;
      h_z0_q  <= g_z0_q;
      h_row_q <= g_row_q;
      h_col_q <= g_col_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: numerator sum
  // --------------------------------------------------------------------------
  logic                      i_write_q;
  logic signed [NUM_W-1:0]   i_num_q;
  logic signed [DEN_W-1:0]   i_den_q;
  logic signed [COORD_W-1:0] i_z0_q;
  logic [ROWCOL_W-1:0]       i_row_q, i_col_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      i_write_q <= h_write_q;
      i_num_q   <= h_np_q[0] + h_np_q[1] + h_np_q[2];
      i_den_q   <= h_den_q;
      i_z0_q    <= h_z0_q;
      i_row_q   <= h_row_q;
      i_col_q   <= h_col_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: magnitudes and quotient sign
  // --------------------------------------------------------------------------
  logic                      j_write_q, j_neg_q, j_dz_q;
  logic [REM_W-1:0]          j_an_q;
  logic [DEN_W-1:0]          j_ad_q;
  logic signed [COORD_W-1:0] j_z0_q;
  logic [ROWCOL_W-1:0]       j_row_q, j_col_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      j_write_q <= i_write_q;
      j_neg_q   <= i_num_q[NUM_W-1] ^ i_den_q[DEN_W-1];
      j_dz_q    <= (i_den_q == '0);
      j_an_q    <= i_num_q[NUM_W-1] ? REM_W'(-i_num_q) : REM_W'(i_num_q);
      j_ad_q    <= i_den_q[DEN_W-1] ? DEN_W'(-i_den_q) : DEN_W'(i_den_q);
      j_z0_q    <= i_z0_q;
      j_row_q   <= i_row_q;
      j_col_q   <= i_col_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: saturation check
  // --------------------------------------------------------------------------
  // The rounded quotient reaches 2^31 exactly when 2*num >= den*(2^32 - 1);
  // below that the quotient fits in 31 bits and the divider needs no more.
  logic [REM_W-1:0] k_an_q;
  logic [DEN_W-1:0] k_ad_q;
  side_t            k_side_q;
  logic [REM_W:0]   j_lim;

  assign j_lim = (REM_W + 1)'({j_ad_q, {COORD_W{1'b0}}}) - (REM_W + 1)'(j_ad_q);

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      k_an_q            <= j_an_q;
      k_ad_q            <= j_ad_q;
      k_side_q.write    <= j_write_q;
      k_side_q.sat      <= ({j_an_q, 1'b0} >= j_lim);
      k_side_q.neg      <= j_neg_q;
      k_side_q.den_zero <= j_dz_q;
      k_side_q.z0       <= j_z0_q;
      k_side_q.row      <= j_row_q;
      k_side_q.col      <= j_col_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 11 to 41: quotient
  // --------------------------------------------------------------------------
  logic [QUO_W-1:0] dv_quo;
  logic [REM_W-1:0] dv_rem;
  logic [DEN_W-1:0] dv_den;
  side_t            dv_side;

  tcli_divider u_div (
    .clk_i  (clk_i),
    .en_i   (en[PRE_STAGES +: DIV_STAGES]),
    .rem_i  (k_an_q),
    .den_i  (k_ad_q),
    .side_i (k_side_q),
    .quo_o  (dv_quo),
    .rem_o  (dv_rem),
    .den_o  (dv_den),
    .side_o (dv_side)
  );

  // --------------------------------------------------------------------------
  // Output stage: rounding, sign, saturation and word packing
  // --------------------------------------------------------------------------
  logic                      rnd_up;
  logic [COORD_W-1:0]        q_rnd;
  logic signed [COORD_W-1:0] alt;
  logic [OUT_W-1:0]          o_data_q;

  assign rnd_up = {dv_rem, 1'b0} >= (REM_W + 1)'(dv_den);
  assign q_rnd  = COORD_W'(dv_quo) + COORD_W'(rnd_up);

  always_comb begin
    if (!dv_side.write) begin
      alt = '0;
    end else if (dv_side.den_zero) begin
      alt = dv_side.z0;
    end else if (dv_side.sat) begin
      alt = dv_side.neg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else if (dv_side.neg) begin
      alt = -q_rnd;
    end else begin
      alt = q_rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      o_data_q <= OUT_W'({dv_side.col, dv_side.row, alt, dv_side.write});
    end
  end

  assign m_axis_tdata = o_data_q;

endmodule

FILE: verif/tin_cell_linear_interpolator_unit_tb.sv
// ----------------------------------------------------------------------------
// tin_cell_linear_interpolator_unit_tb: self-checking interpolator testbench
// Each word drives a triangle and a grid cell into the block. A local exact
// predictor works out the expected coverage and rounded, saturated altitude.
// Every output word is compared with the oldest expected result. Several grid
// settings are covered, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tin_cell_linear_interpolator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcli_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] vx [3];
    logic signed [31:0] vy [3];
    logic signed [31:0] vz [3];
    logic [15:0]        row;
    logic [15:0]        col;
  } tri_cell_t;

  typedef struct {
    logic        wr;
    logic [31:0] alt;
    logic [15:0] row;
    logic [15:0] col;
  } cell_alt_t;

  logic              clk_i, rst_ni;
  logic              s_axis_tvalid, s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid, m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  tin_cell_linear_interpolator_unit dut (.*);

  // Shadow copy of the grid configuration.
  longint org_x, org_y, inv_alt, csize, gcols, grows, etol;

  cell_alt_t alt_queue [$];
  int  n_err, n_words, n_writes, n_sent;
  bit  calm;
  int  hold_req;

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  initial begin
    #400us;
    $display("tb: failure");
    $finish;
  end

  function automatic bit edge_hit(wide_t v, wide_t tol, longint ax, longint bx,
                                  longint ay, longint by);
    wide_t av;
    av = (v < 0) ? -v : v;
    return (av < tol) && (wide_t'(ax) * wide_t'(bx) <= tol) &&
           (wide_t'(ay) * wide_t'(by) <= tol);
  endfunction

  function automatic cell_alt_t predict_cell(tri_cell_t c);
    longint x0, y0, x1, y1, x2, y2, px, py, d0x, d0y, d1x, d1y, d2x, d2y;
    wide_t v01, v12, v20, tol, den, num, an, ad, qt, rm;
    bit neg;
    cell_alt_t r;
    r.row = c.row; r.col = c.col; r.wr = 1'b0; r.alt = '0;
    x0 = c.vx[0]; y0 = c.vy[0]; x1 = c.vx[1]; y1 = c.vy[1];
    x2 = c.vx[2]; y2 = c.vy[2];
    if (c.vz[0] != inv_alt && c.vz[1] != inv_alt && c.vz[2] != inv_alt &&
        c.row < grows && c.col < gcols) begin
      px = org_x + longint'(c.col) * csize;
      py = org_y + longint'(c.row) * csize;
      d0x = px - x0; d0y = py - y0;
      d1x = px - x1; d1y = py - y1;
      d2x = px - x2; d2y = py - y2;
      v01 = wide_t'(x1 - x0) * wide_t'(d1y) - wide_t'(d1x) * wide_t'(y1 - y0);
      v12 = wide_t'(x2 - x1) * wide_t'(d2y) - wide_t'(d2x) * wide_t'(y2 - y1);
      v20 = wide_t'(x0 - x2) * wide_t'(d0y) - wide_t'(d0x) * wide_t'(y0 - y2);
      tol = wide_t'(etol);
      r.wr = (v01 > tol && v12 > tol && v20 > tol) ||
             (v01 < tol && v12 < tol && v20 < tol) ||
             edge_hit(v01, tol, d0x, d1x, d0y, d1y) ||
             edge_hit(v12, tol, d1x, d2x, d1y, d2y) ||
             edge_hit(v20, tol, d2x, d0x, d2y, d0y);
      if (r.wr) begin
        den = v01 + v12 + v20;
        if (den == 0) begin
          r.alt = c.vz[0];
        end else begin
          num = wide_t'(c.vz[0]) * v12 + wide_t'(c.vz[1]) * v20 +
                wide_t'(c.vz[2]) * v01;
          neg = (num < 0) != (den < 0);
          an = (num < 0) ? -num : num;
          ad = (den < 0) ? -den : den;
          qt = an / ad;
          rm = an % ad;
          if (rm >= ad - rm) qt = qt + 1;
          if (qt >= wide_t'(64'sh8000_0000))
            r.alt = neg ? 32'h8000_0000 : 32'h7fff_ffff;
          else
            r.alt = neg ? 32'(-qt) : 32'(qt);
        end
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_grid(longint ox, longint oy, longint cs, longint gc, longint gr,
                          longint inv, longint tol);
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Y, 32'(oy));
    write_reg(REG_CELL_SIZE, 32'(cs));
    write_reg(REG_GRID_COLS, 32'(gc));
    write_reg(REG_GRID_ROWS, 32'(gr));
    write_reg(REG_INV_ALT, 32'(inv));
    write_reg(REG_EDGE_TOL, 32'(tol));
    org_x = longint'(signed'(32'(ox))); org_y = longint'(signed'(32'(oy)));
    csize = cs & 64'h7fff_ffff; gcols = gc & 16'hffff; grows = gr & 16'hffff;
    inv_alt = longint'(signed'(32'(inv))); etol = tol & 20'hfffff;
  endtask

  task automatic send_cell(tri_cell_t c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c.col, c.row, c.vz[2], c.vy[2], c.vx[2], c.vz[1], c.vy[1],
                     c.vx[1], c.vz[0], c.vy[0], c.vx[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    alt_queue.push_back(predict_cell(c));
    n_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (alt_queue.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Output word: write_cell, altitude, out_row, out_col from bit 0 up.
  always @(posedge clk_i) begin
    cell_alt_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_words++;
      if (m_axis_tdata[0]) n_writes++;
      if (alt_queue.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected output word %h", m_axis_tdata);
      end else begin
        e = alt_queue.pop_front();
        if (m_axis_tdata[0] !== e.wr || m_axis_tdata[32:1] !== e.alt ||
            m_axis_tdata[48:33] !== e.row || m_axis_tdata[64:49] !== e.col) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp wr %0b alt %h row %0d col %0d, got wr %0b alt %h row %0d col %0d",
                     e.wr, e.alt, e.row, e.col, m_axis_tdata[0], m_axis_tdata[32:1],
                     m_axis_tdata[48:33], m_axis_tdata[64:49]);
        end
      end
    end
  end

  initial begin
    m_axis_tready = 1'b1;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
      if (hold_req > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [31:0] near(longint p);
    longint r;
    r = longint'($urandom_range(1, 255)) << $urandom_range(0, 20);
    return 32'(p + longint'($urandom_range(0, 32'(2 * r))) - r);
  endfunction

  // Mostly triangles placed around the cell point; the rest are broken cases.
  function automatic tri_cell_t random_cell();
    tri_cell_t c;
    longint px, py;
    int k;
    k = $urandom_range(0, 19);
    c.row = (grows > 0) ? 16'($urandom_range(0, 32'(grows - 1))) : 16'($urandom);
    c.col = (gcols > 0) ? 16'($urandom_range(0, 32'(gcols - 1))) : 16'($urandom);
    px = org_x + longint'(c.col) * csize;
    py = org_y + longint'(c.row) * csize;
    for (int i = 0; i < 3; i++) begin
      c.vx[i] = near(px); c.vy[i] = near(py);
      c.vz[i] = ($urandom_range(0, 3) == 0) ? $urandom : near(0);
    end
    case (k)
      0, 1: begin
        c.row = 16'($urandom); c.col = 16'($urandom);
        for (int i = 0; i < 3; i++) begin
          c.vx[i] = $urandom; c.vy[i] = $urandom; c.vz[i] = $urandom;
        end
      end
      2: c.vz[$urandom_range(0, 2)] = 32'(inv_alt);
      3: c.row = 16'($urandom_range(32'(grows), 65535));
      4: c.col = 16'($urandom_range(32'(gcols), 65535));
      5: begin c.vx[2] = c.vx[1]; c.vy[2] = c.vy[1]; end
      6: begin c.vx[0] = 32'(px); c.vy[0] = 32'(py); end
      7: begin
        c.vx[1] = 32'(2 * px - c.vx[0]); c.vy[1] = 32'(2 * py - c.vy[0]);
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic tri_cell_t make_cell(longint x0, y0, z0, x1, y1, z1, x2, y2, z2,
                                          longint row, col);
    tri_cell_t c;
    c.vx[0] = 32'(x0); c.vy[0] = 32'(y0); c.vz[0] = 32'(z0);
    c.vx[1] = 32'(x1); c.vy[1] = 32'(y1); c.vz[1] = 32'(z1);
    c.vx[2] = 32'(x2); c.vy[2] = 32'(y2); c.vz[2] = 32'(z2);
    c.row = 16'(row); c.col = 16'(col);
    return c;
  endfunction

  task automatic test_directed;
    longint u;
    u = 65536;
    send_cell(make_cell(0, 0, 100*u, 10*u, 0, 200*u, 0, 10*u, 300*u, 1, 1));
    send_cell(make_cell(0, 0, 100*u, 0, 10*u, 300*u, 10*u, 0, 200*u, 2, 3));
    send_cell(make_cell(u, u, 7*u, 9*u, u, 3*u, u, 9*u, -5*u, 1, 1));
    send_cell(make_cell(0, 0, u, 8*u, 0, 2*u, 0, 8*u, 3*u, 0, 4));
    send_cell(make_cell(0, 0, u, 8*u, 0, 2*u, 0, 8*u, 3*u, 20, 20));
    send_cell(make_cell(5*u, 5*u, 9*u, 5*u, 5*u, 2*u, 5*u, 5*u, 3*u, 5, 5));
    send_cell(make_cell(0, 0, 4*u, 4*u, 4*u, 2*u, 8*u, 8*u, 3*u, 2, 2));
    for (int i = 0; i < 3; i++) begin
      tri_cell_t c;
      c = make_cell(0, 0, u, 10*u, 0, u, 0, 10*u, u, 1, 1);
      c.vz[i] = 32'(inv_alt);
      send_cell(c);
    end
    send_cell(make_cell(0, 0, u, 2000*u, 0, u, 0, 2000*u, u, 1024, 1));
    send_cell(make_cell(0, 0, u, 2000*u, 0, u, 0, 2000*u, u, 1, 1024));
    send_cell(make_cell(0, 0, u, 2000*u, 0, u, 0, 2000*u, u, 65535, 65535));
    send_cell(make_cell(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 0, 0));
    send_cell(make_cell(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                        32'h7fffffff, -64'sd2147483648, 32'h7fffffff,
                        -64'sd2147483648, 32'h7fffffff, 0, 1023, 1023));
    send_cell(make_cell(0, 0, 32'h7fffffff, 1, 0, -64'sd2147483648, 0, 1,
                        32'h7fffffff, 0, 0));
    send_cell(make_cell(0, 0, 32'h7fffffff, 3, 1, -64'sd2147483648, 1, 3,
                        -64'sd2147483648, 0, 1));
    send_cell(make_cell(0, -4*u, 0, 1000*u, -4*u, 32'h7fffffff, 0, 1000*u,
                        32'h7fffffff, 1023, 1));
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_cell(random_cell());
    drain();
  endtask

  task automatic test_backpressure;
    hold_req = 300;
    calm = 1'b1;
    repeat (100) send_cell(random_cell());
    calm = 1'b0;
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    n_err = 0; n_words = 0; n_writes = 0; n_sent = 0; calm = 1'b0; hold_req = 0;
    org_x = 0; org_y = 0; csize = 65536; gcols = 1024; grows = 1024;
    inv_alt = -655353446; etol = 42950;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(250);
    set_grid(-64'sd2147483648, 32'h7fff0000, 256, 65535, 65535, 32'h7fffffff, 0);
    test_random(220);
    set_grid($urandom, $urandom, 32'h7fffffff, 3, 2, -64'sd2147483648, 1048575);
    test_random(150);
    set_grid(-100 * 65536, 50 * 65536, 0, 100, 100, 0, 4000);
    test_random(150);
    set_grid(0, 0, 4096, 0, 1, 1, 42950);
    test_random(30);
    set_grid(longint'(signed'($urandom)) >>> 4, longint'(signed'($urandom)) >>> 4,
             $urandom_range(1, 1 << 20), $urandom_range(1, 2000),
             $urandom_range(1, 2000), $urandom, $urandom_range(0, 1048575));
    test_random(250);
    test_backpressure();
    set_grid(3 * 65536, -7 * 65536, 32768, 512, 300, 12345, 100000);
    test_random(150);
    calm = 1'b1;
    test_random(100);

    n_err += alt_queue.size();
    $display("tb: %0d cells sent, %0d words checked, %0d cell writes", n_sent,
             n_words, n_writes);
    $display("tb: grid settings swept, stalls and backpressure on both streams");
    if (n_err == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: tin_cell_linear_interpolator_unit.f
rtl/tcli_pkg.sv
rtl/tcli_divider.sv
rtl/tin_cell_linear_interpolator_unit.sv
verif/tin_cell_linear_interpolator_unit_tb.sv
